FILE: rtl/core/etlca_pkg.sv
`timescale 1ns / 1ps
package etlca_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LEVELS     = 11;
  localparam int TOUR_SLOTS = 2 * MAX_NODES;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int POS_W   = 11;
  localparam int LVL_W   = 4;
  localparam int ENTRY_W = DEPTH_W + NODE_W;
  localparam int TBL_AW  = LVL_W + POS_W;
  localparam int TBL_DEPTH = LEVELS * TOUR_SLOTS;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [POS_W-1:0]   pos_t;

  typedef enum logic [1:0] {
    CMD_LOAD_TOUR  = 2'd0,
    CMD_LOAD_FIRST = 2'd1,
    CMD_BUILD      = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_B_RDA,
    S_B_RDB,
    S_B_WR,
    S_Q_FB,
    S_Q_ORD,
    S_Q_TA,
    S_Q_TB,
    S_Q_CMP
  } state_t;

  // floor(log2(v)) for a range length of 1..TOUR_SLOTS, clamped to the top level
  function automatic lvl_t range_level(input logic [POS_W:0] v);
    lvl_t r;
    r = '0;
    for (int i = 1; i <= POS_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    if (r > LVL_W'(LEVELS - 1)) r = LVL_W'(LEVELS - 1);
    return r;
  endfunction

endpackage

FILE: rtl/core/etlca_req_if.sv
`timescale 1ns / 1ps
interface etlca_req_if
  import etlca_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [POS_W-1:0]    position;
  logic [NODE_W-1:0]   node_id;
  logic [DEPTH_W-1:0]  node_depth;
  logic [NODE_W-1:0]   query_a;
  logic [NODE_W-1:0]   query_b;

  modport source (output valid, command, position, node_id, node_depth, query_a, query_b,
                  input ready);
  modport sink   (input valid, command, position, node_id, node_depth, query_a, query_b,
                  output ready);
endinterface

FILE: rtl/core/etlca_res_if.sv
`timescale 1ns / 1ps
interface etlca_res_if
  import etlca_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   ancestor_node;
  logic [DEPTH_W-1:0]  ancestor_depth;

  modport source (output valid, ancestor_node, ancestor_depth, input ready);
  modport sink   (input valid, ancestor_node, ancestor_depth, output ready);
endinterface

FILE: rtl/core/euler_tour_lca_sparse_table_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | command, position, node_id, node_depth, query_a, query_b
// res     | out | valid/ready   | ancestor_node, ancestor_depth
// cfg     | in  | cfg_we        | cfg_wdata = tour_length
//
// Loads write their RAM when accepted and leave the block ready. A query reads the
// first-position RAM twice, orders the two positions, reads the table RAM twice, each
// read registered, then compares the two entries. A build fills levels 1 to LEVELS-1,
// writing each table entry with two reads and one write on the table RAM.
// rst is synchronous; both RAMs hold garbage until written. A result held by a stalled
// res channel does not block the next request until another query needs the output register.
module euler_tour_lca_sparse_table_top
  import etlca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  etlca_req_if.sink          req,
  etlca_res_if.source        res,
  input  logic               cfg_we,
  input  logic [POS_W-1:0]   cfg_wdata
);

  entry_t tbl_mem [TBL_DEPTH];
  pos_t   fp_mem  [MAX_NODES];

  state_t state, state_next;

  pos_t   tour_length;
  lvl_t   lvl;
  pos_t   idx;
  entry_t hold;
  pos_t   pa, lo, hi;
  lvl_t   lg;
  logic [NODE_W-1:0] qb;

  logic        out_valid;
  entry_t      out_entry;

  logic               tbl_we, tbl_re;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  entry_t             tbl_wdata, tbl_rd;
  logic               fp_we, fp_re;
  logic [NODE_W-1:0]  fp_waddr, fp_raddr;
  pos_t               fp_wdata, fp_rd;

  logic         accept;
  cmd_t         cmd;
  pos_t         half;
  logic         lvl_has_work;
  logic         lvl_last;
  logic [POS_W:0] span;
  lvl_t         lg_c;
  logic [POS_W:0] idx2_w;
  pos_t         idx2;
  logic         out_free;

  assign cmd          = cmd_t'(req.command);
  assign accept       = req.valid && req.ready;
  assign req.ready    = (state == S_IDLE);
  assign half         = POS_W'(1) << (lvl - LVL_W'(1));
  assign lvl_has_work = ({1'b0, idx} + {1'b0, half}) < {1'b0, tour_length};
  assign lvl_last     = (lvl == LVL_W'(LEVELS - 1));
  assign span         = {1'b0, hi} - {1'b0, lo} + (POS_W+1)'(1);
  assign lg_c         = range_level(span);
  assign idx2_w       = {1'b0, hi} + (POS_W+1)'(1) - ((POS_W+1)'(1) << lg);
  assign idx2         = idx2_w[POS_W-1:0];
  assign out_free     = !out_valid || res.ready;

  assign res.valid          = out_valid;
  assign res.ancestor_node  = out_entry[NODE_W-1:0];
  assign res.ancestor_depth = out_entry[ENTRY_W-1:NODE_W];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_BUILD) state_next = S_B_RDA;
        else if (accept && cmd == CMD_QUERY) state_next = S_Q_FB;
      end
      S_B_RDA: begin
        if (lvl_has_work) state_next = S_B_RDB;
        else if (lvl_last) state_next = S_IDLE;
      end
      S_B_RDB: state_next = S_B_WR;
      S_B_WR:  state_next = S_B_RDA;
      S_Q_FB:  state_next = S_Q_ORD;
      S_Q_ORD: state_next = S_Q_TA;
      S_Q_TA:  state_next = S_Q_TB;
      S_Q_TB:  state_next = S_Q_CMP;
      S_Q_CMP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {lvl, idx};
    tbl_wdata = (hold < tbl_rd) ? hold : tbl_rd;
    tbl_re    = 1'b0;
    tbl_raddr = {lvl - LVL_W'(1), idx};
    fp_we     = 1'b0;
    fp_waddr  = req.node_id;
    fp_wdata  = req.position;
    fp_re     = 1'b0;
    fp_raddr  = req.query_a;
    case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_LOAD_TOUR) begin
          tbl_we    = 1'b1;
          tbl_waddr = {LVL_W'(0), req.position};
          tbl_wdata = {req.node_depth, req.node_id};
        end
        fp_we = accept && cmd == CMD_LOAD_FIRST;
        fp_re = accept && cmd == CMD_QUERY;
      end
      S_B_RDA: tbl_re = lvl_has_work;
      S_B_RDB: begin
        tbl_re    = 1'b1;
        tbl_raddr = {lvl - LVL_W'(1), idx + half};
      end
      S_B_WR:  tbl_we = 1'b1;
      S_Q_FB: begin
        fp_re    = 1'b1;
        fp_raddr = qb;
      end
      S_Q_TA: begin
        tbl_re    = 1'b1;
        tbl_raddr = {lg_c, lo};
      end
      S_Q_TB: begin
        tbl_re    = 1'b1;
        tbl_raddr = {lg, idx2};
      end
      default: ;
    endcase
  end

  // memories; read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (fp_we) fp_mem[fp_waddr] <= fp_wdata;
    if (fp_re) fp_rd <= fp_mem[fp_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tour_length <= POS_W'(1);
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) tour_length <= cfg_wdata;
      if (state == S_Q_CMP && out_free) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lvl <= LVL_W'(1);
        idx <= '0;
        qb  <= req.query_b;
      end
      S_B_RDA: begin
        if (!lvl_has_work && !lvl_last) begin
          lvl <= lvl + LVL_W'(1);
          idx <= '0;
        end
      end
      S_B_RDB: hold <= tbl_rd;
      S_B_WR:  idx <= idx + POS_W'(1);
      S_Q_FB:  pa <= fp_rd;
      S_Q_ORD: begin
        lo <= (pa > fp_rd) ? fp_rd : pa;
        hi <= (pa > fp_rd) ? pa : fp_rd;
      end
      S_Q_TA:  lg <= lg_c;
      S_Q_TB:  hold <= tbl_rd;
      S_Q_CMP: begin
        if (out_free) out_entry <= (hold < tbl_rd) ? hold : tbl_rd;
      end
      default: ;
    endcase
  end

  a_res_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_Q_CMP)
    else $error("result raised outside query compare");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_FB || state == S_Q_ORD || state == S_Q_TA || state == S_Q_TB ||
     state == S_Q_CMP) |-> !tbl_we && !fp_we)
    else $error("memory write during query");

  a_build_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_RDA || state == S_B_RDB || state == S_B_WR) |->
    lvl != LVL_W'(0) && lvl <= LVL_W'(LEVELS - 1))
    else $error("build level out of range");

  a_build_write_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_B_WR |-> ({1'b0, idx} + {1'b0, half}) < {1'b0, tour_length})
    else $error("build wrote past tour length");

endmodule
